// File: hdl/positional_stack_queue_buffer_macros.svh
// Assertion macros for the positional stack/queue buffer.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef POSITIONAL_STACK_QUEUE_BUFFER_MACROS_SVH
`define POSITIONAL_STACK_QUEUE_BUFFER_MACROS_SVH

// Plain invariant, checked out of reset.
`define PSQB_ASSERT(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Implication into the next cycle.
`define PSQB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/psqb_pkg.sv
// Shared types, constants and helpers for the positional stack/queue buffer.
// No dependencies.
`default_nettype none

package psqb_pkg;

    localparam int DEPTH      = 16;
    localparam int POS_W      = 5;
    localparam int DATA_W     = 8;
    localparam int COUNT_O_W  = 5;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int INIT_COUNT = 4;
    localparam logic [DATA_W-1:0] FIRST_LETTER = 8'h41;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_POP_AT = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_WRONG_POS = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER,
        CELL_LOAD,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] load_val;
    } cell_ctl_t;

    typedef logic [DEPTH-1:0][DATA_W-1:0] entry_row_t;
    typedef cell_ctl_t [DEPTH-1:0]        ctl_row_t;

    function automatic logic [DATA_W-1:0] init_value(int i);
        logic [DATA_W-1:0] v;
        v = '0;
        if (i < INIT_COUNT) begin
            v = FIRST_LETTER + DATA_W'(i);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/positional_stack_queue_buffer.sv
// Top level of the positional stack/queue buffer: row of cells, decode, result register.
// Depends on psqb_pkg, psqb_cell, psqb_ctrl and the assertion macro header.
//
//   channel | direction | handshake             | payload
//   s_      | in        | s_tvalid / s_tready   | command, position, value
//   m_      | out       | m_tvalid / m_tready   | status, removed_value, entry_count
//   cfg_    | in        | cfg_valid / cfg_ready | queue_mode
//
// One command per cycle while s_tready is high: all cells shift, load, clear or hold
// in parallel at the edge that accepts a transaction, and the result register loads at
// that same edge, so m_tvalid rises in the cycle after acceptance.
// s_tready is low only while a held result is stalled by m_tready.
// Reset loads A, B, C, D into the four oldest cells, count four, stack mode.
`default_nettype none
`include "positional_stack_queue_buffer_macros.svh"

module positional_stack_queue_buffer import psqb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // command[1:0], position[6:2], value[14:7]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // status[1:0], removed_value[9:2], entry_count[14:10]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    logic              queue_mode_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic              s_fire;
    cmd_t              s_command;
    logic [POS_W-1:0]  s_position;
    logic [DATA_W-1:0] s_value;
    entry_row_t        entries;
    ctl_row_t          cell_ctl;
    status_t           status;
    logic [DATA_W-1:0] removed_value;
    logic              grow_fire;
    logic [CNT_W-1:0]  count_inc;
    logic              empty_result;

    assign s_command  = cmd_t'(s_tdata[1:0]);
    assign s_position = s_tdata[6:2];
    assign s_value    = s_tdata[14:7];
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    psqb_ctrl u_ctrl (
        .fire          (s_fire),
        .command       (s_command),
        .position      (s_position),
        .value         (s_value),
        .queue_mode    (queue_mode_reg),
        .count         (count_reg),
        .entries       (entries),
        .cell_ctl      (cell_ctl),
        .status        (status),
        .removed_value (removed_value),
        .count_next    (count_next)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] lower_val;
        logic [DATA_W-1:0] upper_val;

        if (i == 0) begin : g_first
            assign lower_val = '0;
        end else begin : g_lower
            assign lower_val = entries[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign upper_val = '0;
        end else begin : g_upper
            assign upper_val = entries[i+1];
        end

        psqb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .init_val  (init_value(i)),
            .lower_val (lower_val),
            .upper_val (upper_val),
            .ctl       (cell_ctl[i]),
            .data      (entries[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_mode_reg <= 1'b0;
            count_reg      <= CNT_W'(INIT_COUNT);
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                queue_mode_reg <= cfg_data;
            end
            if (s_fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= {1'b0, COUNT_O_W'(count_next), removed_value, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign grow_fire    = s_fire && s_command == CMD_PUSH && count_reg != CNT_W'(DEPTH);
    assign count_inc    = count_reg + CNT_W'(1);
    assign empty_result = m_tvalid_reg && status_t'(m_tdata_reg[1:0]) == ST_EMPTY;

    `PSQB_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "count above depth")
    `PSQB_ASSERT_NEXT(a_push_grows, grow_fire, count_reg == $past(count_inc), "count did not grow")
    `PSQB_ASSERT(a_empty_result, !empty_result || m_tdata_reg[14:2] == '0, "empty result with data")

endmodule

`default_nettype wire

// File: hdl/psqb_cell.sv
// One storage cell of the buffer row: holds a byte, shifts from a neighbor,
// loads, or clears. Depends on psqb_pkg.
`default_nettype none

module psqb_cell import psqb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [DATA_W-1:0] init_val,
    input  wire logic [DATA_W-1:0] lower_val,
    input  wire logic [DATA_W-1:0] upper_val,
    input  wire cell_ctl_t         ctl,
    output logic      [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        case (ctl.op)
            CELL_FROM_LOWER: data_next = lower_val;
            CELL_FROM_UPPER: data_next = upper_val;
            CELL_LOAD:       data_next = ctl.load_val;
            CELL_CLEAR:      data_next = '0;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= init_val;
        end else begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: hdl/psqb_ctrl.sv
// Command decode: per-cell shift controls, status, removed entry and new count.
// Depends on psqb_pkg.
`default_nettype none

module psqb_ctrl import psqb_pkg::*; (
    input  wire logic              fire,
    input  wire cmd_t              command,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic              queue_mode,
    input  wire logic [CNT_W-1:0]  count,
    input  wire entry_row_t        entries,
    output ctl_row_t               cell_ctl,
    output status_t                status,
    output logic      [DATA_W-1:0] removed_value,
    output logic      [CNT_W-1:0]  count_next
);

    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] idx;
    logic             do_insert;
    logic             do_remove;

    always_comb begin
        cnt_ext   = CMP_W'(count);
        pos_ext   = CMP_W'(position);
        idx       = '0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        status    = ST_OK;

        case (command)
            CMD_PUSH: begin
                if (cnt_ext >= CMP_W'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    if (pos_ext >= CMP_W'(1) && pos_ext <= cnt_ext + CMP_W'(1)) begin
                        idx = pos_ext - CMP_W'(1);
                    end else begin
                        idx = cnt_ext;
                    end
                end
            end
            CMD_POP: begin
                if (cnt_ext == '0) begin
                    status = ST_EMPTY;
                end else begin
                    do_remove = 1'b1;
                    idx = queue_mode ? '0 : cnt_ext - CMP_W'(1);
                end
            end
            CMD_POP_AT: begin
                if (cnt_ext == '0) begin
                    status = ST_EMPTY;
                end else if (pos_ext < CMP_W'(1) || pos_ext > cnt_ext) begin
                    status = ST_WRONG_POS;
                end else begin
                    do_remove = 1'b1;
                    idx = pos_ext - CMP_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase

        removed_value = do_remove ? entries[idx[IDX_W-1:0]] : '0;

        if (do_insert) begin
            count_next = count + CNT_W'(1);
        end else if (do_remove) begin
            count_next = count - CNT_W'(1);
        end else begin
            count_next = count;
        end

        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i].load_val = value;
            cell_ctl[i].op       = CELL_HOLD;
            if (fire && do_insert) begin
                if (CMP_W'(i) == idx) begin
                    cell_ctl[i].op = CELL_LOAD;
                end else if (CMP_W'(i) > idx && CMP_W'(i) <= cnt_ext) begin
                    cell_ctl[i].op = CELL_FROM_LOWER;
                end
            end else if (fire && do_remove) begin
                if (CMP_W'(i) == cnt_ext - CMP_W'(1)) begin
                    cell_ctl[i].op = CELL_CLEAR;
                end else if (CMP_W'(i) >= idx && CMP_W'(i) < cnt_ext - CMP_W'(1)) begin
                    cell_ctl[i].op = CELL_FROM_UPPER;
                end
            end
        end
    end

endmodule

`default_nettype wire
